/* src/q2e_pkg.sv */
// Shared types, constants and the arctangent table for the quaternion to Euler core.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps

package q2e_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ANGLE_WIDTH_DEF   = 16;
	localparam int ATAN_TAB_LEN      = 24;
	localparam int SQRT_STEPS        = 32;

	localparam logic [11:0] MARGIN_RESET = 12'd1;

	localparam logic [1:0] LOCK_NONE = 2'd0;
	localparam logic [1:0] LOCK_POS  = 2'd1;
	localparam logic [1:0] LOCK_NEG  = 2'd2;

	localparam logic [31:0] ANG_PI      = 32'h8000_0000;
	localparam logic [31:0] ANG_HALF_PI = 32'h4000_0000;
	localparam logic [31:0] ANG_NEG_HALF_PI = 32'hC000_0000;

	// One CORDIC lane: operands and the accumulated 32-bit binary angle.
	typedef struct packed {
		logic signed [35:0] x;
		logic signed [35:0] y;
		logic [31:0]        ang;
		logic               zero;
	} cordic_t;

	// Digit-by-digit square root state: remainder and shifted root.
	typedef struct packed {
		logic [63:0] rem;
		logic [63:0] root;
	} sqrt_t;

	// Data that rides alongside the square root cells.
	typedef struct packed {
		logic signed [35:0] yaw_x;
		logic signed [35:0] yaw_y;
		logic signed [35:0] roll_x;
		logic signed [35:0] roll_y;
		logic [31:0]        asin_a;
		logic               s_neg;
		logic [1:0]         lock;
	} carry_t;

	// atan(2^-i) as a 32-bit binary angle.
	function automatic logic [31:0] atan_entry(input int idx);
		logic [31:0] r;
		unique case (idx)
			0: r = 32'h20000000;  1: r = 32'h12E4051E;  2: r = 32'h09FB385B;
			3: r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
			6: r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
			9: r = 32'h00145F2F; 10: r = 32'h000A2F98; 11: r = 32'h000517CC;
			12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2FA;
			15: r = 32'h0000517D; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
			18: r = 32'h00000A30; 19: r = 32'h00000518; 20: r = 32'h0000028C;
			21: r = 32'h00000146; 22: r = 32'h000000A3; 23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

endpackage

/* src/q2e_front.sv */
// Front pipeline: products, norm, singularity test and CORDIC operand selection.
// Depends on q2e_pkg.
`timescale 1ns / 1ps

module q2e_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [15:0]   quat_w,
	input  logic signed [15:0]   quat_x,
	input  logic signed [15:0]   quat_y,
	input  logic signed [15:0]   quat_z,
	input  logic [11:0]          gimbal_margin,
	output logic                 out_valid,
	output q2e_pkg::sqrt_t       out_sqrt,
	output q2e_pkg::carry_t      out_carry
);

	// Stage 1: exact Q2.30 products.
	logic              vld_s1;
	logic [30:0]       w2_s1, x2_s1, y2_s1, z2_s1;
	logic signed [31:0] wx_s1, yz_s1, wz_s1, xy_s1, wy_s1, xz_s1;
	logic signed [15:0] w_s1, y_s1;

	logic signed [31:0] w2p, x2p, y2p, z2p;
	assign w2p = quat_w * quat_w;
	assign x2p = quat_x * quat_x;
	assign y2p = quat_y * quat_y;
	assign z2p = quat_z * quat_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w2_s1 <= w2p[30:0];
			x2_s1 <= x2p[30:0];
			y2_s1 <= y2p[30:0];
			z2_s1 <= z2p[30:0];
			wx_s1 <= quat_w * quat_x;
			yz_s1 <= quat_y * quat_z;
			wz_s1 <= quat_w * quat_z;
			xy_s1 <= quat_x * quat_y;
			wy_s1 <= quat_w * quat_y;
			xz_s1 <= quat_x * quat_z;
			w_s1  <= quat_w;
			y_s1  <= quat_y;
		end
	end

	// Stage 2: sums, norm halves and the clamped asin numerator.
	logic              vld_s2;
	logic [32:0]       norm_s2;
	logic signed [32:0] s_s2, adbc_s2, acbd_s2;
	logic signed [35:0] yawx_s2, rollx_s2;
	logic [31:0]       m_s2, a_s2;
	logic signed [15:0] w_s2, y_s2;

	logic [32:0]       norm_c;
	logic signed [32:0] s_c;
	logic [31:0]       abs_s, m_c;
	logic [31:0]       zx_sum, yx_sum;

	always_comb begin
		norm_c = 33'(w2_s1) + 33'(x2_s1) + 33'(y2_s1) + 33'(z2_s1);
		s_c    = 33'(wx_s1) + 33'(yz_s1);
		abs_s  = s_c[32] ? 32'(-s_c) : s_c[31:0];
		m_c    = norm_c[32:1];
		zx_sum = 32'(z2_s1) + 32'(x2_s1);
		yx_sum = 32'(y2_s1) + 32'(x2_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			norm_s2  <= norm_c;
			s_s2     <= s_c;
			adbc_s2  <= 33'(wz_s1) - 33'(xy_s1);
			acbd_s2  <= 33'(wy_s1) - 33'(xz_s1);
			yawx_s2  <= (36'sd1 <<< 30) - $signed({3'b000, zx_sum, 1'b0});
			rollx_s2 <= (36'sd1 <<< 30) - $signed({3'b000, yx_sum, 1'b0});
			m_s2     <= m_c;
			a_s2     <= (abs_s > m_c) ? m_c : abs_s;
			w_s2     <= w_s1;
			y_s2     <= y_s1;
		end
	end

	// Stage 3: bound product and the squares for the asin cosine term.
	logic              vld_s3;
	logic [48:0]       bound_s3;
	logic signed [48:0] lhs_s3;
	logic [63:0]       mm_s3, aa_s3;
	logic signed [32:0] adbc_s3, acbd_s3;
	logic signed [35:0] yawx_s3, rollx_s3;
	logic [31:0]       a_s3;
	logic              sneg_s3;
	logic signed [15:0] w_s3, y_s3;

	logic [15:0] scale;
	assign scale = 16'd32768 - 16'(gimbal_margin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bound_s3 <= 49'(scale) * 49'(norm_s2);
			lhs_s3   <= {s_s2, 16'h0000};
			mm_s3    <= 64'(m_s2) * 64'(m_s2);
			aa_s3    <= 64'(a_s2) * 64'(a_s2);
			adbc_s3  <= adbc_s2;
			acbd_s3  <= acbd_s2;
			yawx_s3  <= yawx_s2;
			rollx_s3 <= rollx_s2;
			a_s3     <= a_s2;
			sneg_s3  <= s_s2[32];
			w_s3     <= w_s2;
			y_s3     <= y_s2;
		end
	end

	// Stage 4: gimbal-lock decision and operand selection.
	logic              vld_s4;
	q2e_pkg::sqrt_t    sq_s4;
	q2e_pkg::carry_t   car_s4;

	logic signed [50:0] lhs_x, bnd_x;
	logic [1:0]        lock_c;

	always_comb begin
		lhs_x = 51'(lhs_s3);
		bnd_x = $signed({2'b00, bound_s3});
		priority if (lhs_x > bnd_x) lock_c = q2e_pkg::LOCK_POS;
		else if (lhs_x < -bnd_x)    lock_c = q2e_pkg::LOCK_NEG;
		else                        lock_c = q2e_pkg::LOCK_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (en) vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s4.rem  <= mm_s3 - aa_s3;
			sq_s4.root <= 64'd0;
			if (lock_c != q2e_pkg::LOCK_NONE) begin
				car_s4.yaw_x <= 36'(w_s3);
				car_s4.yaw_y <= 36'(y_s3);
			end else begin
				car_s4.yaw_x <= yawx_s3;
				car_s4.yaw_y <= 36'(adbc_s3) <<< 1;
			end
			car_s4.roll_x <= rollx_s3;
			car_s4.roll_y <= 36'(acbd_s3) <<< 1;
			car_s4.asin_a <= a_s3;
			car_s4.s_neg  <= sneg_s3;
			car_s4.lock   <= lock_c;
		end
	end

	assign out_valid = vld_s4;
	assign out_sqrt  = sq_s4;
	assign out_carry = car_s4;

endmodule

/* src/q2e_sqrt_cell.sv */
// One digit step of the integer square root chain, two radicand bits per cell.
// Depends on q2e_pkg.
`timescale 1ns / 1ps

module q2e_sqrt_cell #(
	parameter int STEP = 0
) (
	input  logic            clk,
	input  logic            en,
	input  q2e_pkg::sqrt_t  in_st,
	output q2e_pkg::sqrt_t  out_st
);

	localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

	logic [63:0]    trial;
	q2e_pkg::sqrt_t nxt;

	always_comb begin
		trial = in_st.root + BIT;
		if (in_st.rem >= trial) begin
			nxt.rem  = in_st.rem - trial;
			nxt.root = (in_st.root >> 1) + BIT;
		end else begin
			nxt.rem  = in_st.rem;
			nxt.root = in_st.root >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) out_st <= nxt;
	end

endmodule

/* src/q2e_cordic_cell.sv */
// One vectoring CORDIC micro-rotation with a fixed shift and table angle.
// Depends on q2e_pkg.
`timescale 1ns / 1ps

module q2e_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic             clk,
	input  logic             en,
	input  q2e_pkg::cordic_t in_st,
	output q2e_pkg::cordic_t out_st
);

	localparam logic [31:0] ATAN = q2e_pkg::atan_entry(IDX);

	logic signed [35:0] dx, dy;
	q2e_pkg::cordic_t   nxt;

	always_comb begin
		dx  = in_st.y >>> IDX;
		dy  = in_st.x >>> IDX;
		nxt = in_st;
		if (!in_st.y[35]) begin
			nxt.x   = in_st.x + dx;
			nxt.y   = in_st.y - dy;
			nxt.ang = in_st.ang + ATAN;
		end else begin
			nxt.x   = in_st.x - dx;
			nxt.y   = in_st.y + dy;
			nxt.ang = in_st.ang - ATAN;
		end
	end

	always_ff @(posedge clk) begin
		if (en) out_st <= nxt;
	end

endmodule

/* src/quaternion_to_euler_core.sv */
// Top level of the quaternion to Euler converter: square root and CORDIC cell chains.
// Depends on q2e_pkg, q2e_front, q2e_sqrt_cell and q2e_cordic_cell.
`timescale 1ns / 1ps

// Takes one quaternion beat per clock and returns one Euler beat per clock while the
// output is not stalled, fully pipelined. It has four front stages for products and
// the gimbal-lock test, 32 square root cells, one CORDIC pre-rotation stage,
// CORDIC_STAGES micro-rotation cells in each of three parallel lanes, and the output
// register. A stalled output holds the whole chain; an empty output slot lets it run.
module quaternion_to_euler_core #(
	parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF,
	parameter int ANGLE_WIDTH   = q2e_pkg::ANGLE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [11:0] cfg_wdata,   // gimbal_margin
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,     // quat_w, quat_x, quat_y, quat_z
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,     // yaw_angle, pitch_angle, roll_angle
	output logic [1:0]  m_tuser      // lock_case
);

	localparam int NSQ = q2e_pkg::SQRT_STEPS;
	localparam logic [31:0] FIELD_MASK = ~((32'd1 << (32 - ANGLE_WIDTH)) - 32'd1);

	logic [11:0] margin_q;
	logic        en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) margin_q <= q2e_pkg::MARGIN_RESET;
		else if (cfg_we) margin_q <= cfg_wdata;
	end

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	logic            front_vld;
	q2e_pkg::sqrt_t  front_sq;
	q2e_pkg::carry_t front_car;

	q2e_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (s_tvalid),
		.quat_w        (s_tdata[15:0]),
		.quat_x        (s_tdata[31:16]),
		.quat_y        (s_tdata[47:32]),
		.quat_z        (s_tdata[63:48]),
		.gimbal_margin (margin_q),
		.out_valid     (front_vld),
		.out_sqrt      (front_sq),
		.out_carry     (front_car)
	);

	// Square root chain with its side data.
	q2e_pkg::sqrt_t  sq   [NSQ+1];
	q2e_pkg::carry_t car_q[NSQ+1];
	logic            sv_q [NSQ+1];

	assign sq[0]    = front_sq;
	assign car_q[0] = front_car;
	assign sv_q[0]  = front_vld;

	for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
		q2e_sqrt_cell #(.STEP(k)) u_cell (
			.clk    (clk),
			.en     (en),
			.in_st  (sq[k]),
			.out_st (sq[k+1])
		);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sv_q[k+1] <= 1'b0;
			else if (en) sv_q[k+1] <= sv_q[k];
		end
		always_ff @(posedge clk) begin
			if (en) car_q[k+1] <= car_q[k];
		end
	end

	// Pre-rotation by pi for a negative x operand.
	function automatic q2e_pkg::cordic_t pre_rot(input logic signed [35:0] y,
			input logic signed [35:0] x);
		q2e_pkg::cordic_t r;
		r.zero = (x == 36'sd0) && (y == 36'sd0);
		if (x[35]) begin
			r.x   = -x;
			r.y   = -y;
			r.ang = q2e_pkg::ANG_PI;
		end else begin
			r.x   = x;
			r.y   = y;
			r.ang = 32'd0;
		end
		return r;
	endfunction

	q2e_pkg::cordic_t yaw_c [CORDIC_STAGES+1];
	q2e_pkg::cordic_t pit_c [CORDIC_STAGES+1];
	q2e_pkg::cordic_t rol_c [CORDIC_STAGES+1];
	logic             cv_q  [CORDIC_STAGES+1];
	logic [1:0]       lk_q  [CORDIC_STAGES+1];
	logic             sn_q  [CORDIC_STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cv_q[0] <= 1'b0;
		else if (en) cv_q[0] <= sv_q[NSQ];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			yaw_c[0] <= pre_rot(car_q[NSQ].yaw_y, car_q[NSQ].yaw_x);
			pit_c[0] <= pre_rot($signed({4'b0000, car_q[NSQ].asin_a}),
				$signed({4'b0000, sq[NSQ].root[31:0]}));
			rol_c[0] <= pre_rot(car_q[NSQ].roll_y, car_q[NSQ].roll_x);
			lk_q[0]  <= car_q[NSQ].lock;
			sn_q[0]  <= car_q[NSQ].s_neg;
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		q2e_cordic_cell #(.IDX(i)) u_yaw (
			.clk(clk), .en(en), .in_st(yaw_c[i]), .out_st(yaw_c[i+1]));
		q2e_cordic_cell #(.IDX(i)) u_pitch (
			.clk(clk), .en(en), .in_st(pit_c[i]), .out_st(pit_c[i+1]));
		q2e_cordic_cell #(.IDX(i)) u_roll (
			.clk(clk), .en(en), .in_st(rol_c[i]), .out_st(rol_c[i+1]));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) cv_q[i+1] <= 1'b0;
			else if (en) cv_q[i+1] <= cv_q[i];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				lk_q[i+1] <= lk_q[i];
				sn_q[i+1] <= sn_q[i];
			end
		end
	end

	// Final angle assembly.
	logic [31:0] yaw_raw, pit_raw, rol_raw, yaw_f, pit_f, rol_f;
	logic [1:0]  lk;

	always_comb begin
		lk      = lk_q[CORDIC_STAGES];
		yaw_raw = yaw_c[CORDIC_STAGES].zero ? 32'd0 : yaw_c[CORDIC_STAGES].ang;
		pit_raw = pit_c[CORDIC_STAGES].zero ? 32'd0 : pit_c[CORDIC_STAGES].ang;
		rol_raw = rol_c[CORDIC_STAGES].zero ? 32'd0 : rol_c[CORDIC_STAGES].ang;
		unique case (lk)
			q2e_pkg::LOCK_POS: begin
				yaw_f = yaw_raw << 1;
				pit_f = q2e_pkg::ANG_HALF_PI;
				rol_f = 32'd0;
			end
			q2e_pkg::LOCK_NEG: begin
				yaw_f = 32'd0 - (yaw_raw << 1);
				pit_f = q2e_pkg::ANG_NEG_HALF_PI;
				rol_f = 32'd0;
			end
			default: begin
				yaw_f = yaw_raw;
				pit_f = sn_q[CORDIC_STAGES] ? 32'd0 - pit_raw : pit_raw;
				rol_f = rol_raw;
			end
		endcase
		yaw_f = yaw_f & FIELD_MASK;
		pit_f = pit_f & FIELD_MASK;
		rol_f = rol_f & FIELD_MASK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (en) m_tvalid <= cv_q[CORDIC_STAGES];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {rol_f[31:16], pit_f[31:16], yaw_f[31:16]};
			m_tuser <= lk;
		end
	end

endmodule
